/* rtl/core/programmable_priority_fsm_engine_top_macros.svh */
// Assertion helpers for the priority FSM engine.
// They expect i_clk and i_rst_n in the enclosing module.
`ifndef PROGRAMMABLE_PRIORITY_FSM_ENGINE_TOP_MACROS_SVH
`define PROGRAMMABLE_PRIORITY_FSM_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define PPFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ppfe_pkg.sv */
package ppfe_pkg;

    localparam int MAX_STATES = 16;
    localparam int MAX_EVENTS = 16;
    localparam int PRIO_W     = 16;   // widest stored priority

    // request operations
    localparam logic [2:0] OP_WR_SLOT = 3'd0;
    localparam logic [2:0] OP_WR_EN   = 3'd1;
    localparam logic [2:0] OP_WR_FB   = 3'd2;
    localparam logic [2:0] OP_EVENT   = 3'd3;
    localparam logic [2:0] OP_REEVAL  = 3'd4;
    localparam logic [2:0] OP_FORCE   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_STATE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_EVENT_COUNT   = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_STATE = 2'd2;
    localparam logic [1:0] CFG_DEFAULT_SET   = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] state_idx;
        logic [2:0] slot_idx;
        logic [3:0] event_id;
        logic [3:0] target_idx;
        logic       target_is_last;
        logic [7:0] priority_req;
        logic       entry_valid;
        logic       enable;
        logic [3:0] fallback_idx;
        logic       fallback_valid;
        logic       enter_default;
    } t_req;

    typedef struct packed {
        logic [3:0] current_state;
        logic       current_valid;
        logic [3:0] previous_state;
        logic       changed;
        logic       accepted;
    } t_rsp;

    // one transition slot
    typedef struct packed {
        logic              valid;
        logic [3:0]        ev;
        logic [3:0]        tgt;
        logic              to_last;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    // index below a 5-bit count register
    function automatic logic fits(input logic [3:0] idx, input logic [4:0] cnt);
        return {1'b0, idx} < cnt;
    endfunction

endpackage

/* rtl/core/ppfe_slot_ram.sv */
module ppfe_slot_ram #(
    parameter int SLOTS_PER_STATE = 8,
    parameter int PRIORITY_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    output logic                 o_ready,
    input  logic                 i_wr_en,
    input  logic [4+((SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1)-1:0] i_wr_addr,
    input  ppfe_pkg::t_slot      i_wr_data,
    input  logic                 i_rd_en,
    input  logic [4+((SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1)-1:0] i_rd_addr,
    output ppfe_pkg::t_slot      o_rd_data
);
    import ppfe_pkg::*;

    localparam int SW    = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
    localparam int AW    = 4 + SW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = 10 + PRIORITY_BITS;

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] r_rd_word;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_busy;
    logic [DW-1:0] wr_word;

    assign wr_word = {i_wr_data.valid, i_wr_data.ev, i_wr_data.tgt, i_wr_data.to_last,
                      i_wr_data.prio[PRIORITY_BITS-1:0]};

    // clearing sweep after reset, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= wr_word;
        end
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_addr];
        end
    end

    assign o_ready           = !r_clr_busy;
    assign o_rd_data.valid   = r_rd_word[DW-1];
    assign o_rd_data.ev      = r_rd_word[DW-2 -: 4];
    assign o_rd_data.tgt     = r_rd_word[DW-6 -: 4];
    assign o_rd_data.to_last = r_rd_word[PRIORITY_BITS];
    assign o_rd_data.prio    = PRIO_W'(r_rd_word[PRIORITY_BITS-1:0]);

endmodule

/* rtl/core/programmable_priority_fsm_engine_top.sv */
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_in_req  (ppfe_pkg::t_req)
// result    out        o_out_valid / i_out_stall  o_out_rsp (ppfe_pkg::t_rsp)
// config    in         i_cfg_we, no wait          i_cfg_idx, i_cfg_data
//
// Applied event request: the result waits for the slot scan, which reads and compares one
//   table word a cycle, walking all SLOTS_PER_STATE slots of the current state.
// Every other request, a refused event included, skips the scan. One request in flight; a new
//   one is taken on the cycle after the result is loaded, even if that result is still stalled.
// After reset the slot table is swept clear, all 16 * 2^SW words (128 by default),
//   with o_in_stall high; config writes still land.
// Result register holds while it is valid and i_out_stall is high.
`include "programmable_priority_fsm_engine_top_macros.svh"

module programmable_priority_fsm_engine_top #(
    parameter int SLOTS_PER_STATE = 8,
    parameter int PRIORITY_BITS   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ppfe_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ppfe_pkg::t_rsp o_out_rsp,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [4:0]     i_cfg_data
);
    import ppfe_pkg::*;

    localparam int SW = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
    localparam int AW = 4 + SW;
    localparam logic [SW:0]       SLOTS_C   = (SW + 1)'(SLOTS_PER_STATE);
    localparam logic [6:0]        SLOTS_L   = 7'(SLOTS_PER_STATE);
    localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((32'd1 << PRIORITY_BITS) - 32'd1);

    // sequencer codes
    localparam logic [2:0] S_INIT = 3'd0;  // table sweep running
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;  // decode and apply
    localparam logic [2:0] S_SCAN = 3'd3;  // slot walk for an event
    localparam logic [2:0] S_RESP = 3'd4;  // load result register

    // configuration
    logic [4:0] r_state_count;
    logic [4:0] r_event_count;
    logic [3:0] r_default_state;
    logic       r_default_set;

    // engine state
    logic [3:0] r_cur;
    logic       r_cur_known;
    logic [3:0] r_prev;
    logic       r_prev_known;
    logic [MAX_STATES-1:0] r_en;
    logic [MAX_STATES-1:0] r_fb_ok;
    logic [3:0] r_fb [0:MAX_STATES-1];

    // sequencer
    logic [2:0]               r_state;
    t_req                     r_req;
    logic [SW:0]              r_slot;
    logic                     r_pend;
    logic                     r_found;
    logic [PRIORITY_BITS-1:0] r_best;
    logic [3:0]               r_dest;
    logic                     r_acc;
    logic                     r_chg;
    logic                     r_out_valid;
    t_rsp                     r_out;

    logic                     ram_ready;
    t_slot                    rd;
    t_slot                    wr_data;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    logic                     in_acc;
    logic                     cur_ok;
    logic                     default_ok;
    logic                     slot_wr_ok;
    logic                     scan_issue;
    logic                     scan_done;
    logic                     hit;
    logic [3:0]               cand;
    logic                     take;
    logic                     n_found;
    logic [PRIORITY_BITS-1:0] n_best;
    logic [3:0]               n_dest;
    logic                     mv_en;
    logic [3:0]               mv_tgt;
    logic                     resp_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cur_ok     = r_cur_known && fits(r_cur, r_state_count);
    assign default_ok = r_default_set && fits(r_default_state, r_state_count);

    // slot write legality: clearing needs only a live state and slot
    assign slot_wr_ok = fits(r_req.state_idx, r_state_count)
                     && ({4'd0, r_req.slot_idx} < SLOTS_L)
                     && (!r_req.entry_valid
                         || (fits(r_req.event_id, r_event_count)
                             && (r_req.target_is_last
                                 || fits(r_req.target_idx, r_state_count))));

    assign wr_en           = (r_state == S_EXEC) && (r_req.op == OP_WR_SLOT) && slot_wr_ok;
    assign wr_addr         = {r_req.state_idx, SW'(r_req.slot_idx)};
    assign wr_data.valid   = r_req.entry_valid;
    assign wr_data.ev      = r_req.event_id;
    assign wr_data.tgt     = r_req.target_is_last ? 4'd0 : r_req.target_idx;
    assign wr_data.to_last = r_req.target_is_last;
    assign wr_data.prio    = {8'd0, r_req.priority_req} & PRIO_MASK;

    // slot scan: read slot k while judging slot k-1
    assign scan_issue = (r_state == S_SCAN) && (r_slot < SLOTS_C);
    assign scan_done  = (r_state == S_SCAN) && r_pend && (r_slot == SLOTS_C);
    assign rd_addr    = {r_cur, r_slot[SW-1:0]};

    assign hit  = r_pend && rd.valid && (rd.ev == r_req.event_id)
               && (!r_found || (rd.prio[PRIORITY_BITS-1:0] > r_best));
    assign cand = rd.to_last ? r_prev : rd.tgt;
    assign take = hit && (!rd.to_last || r_prev_known)
               && fits(cand, r_state_count) && r_en[cand];

    assign n_found = r_found || take;
    assign n_best  = take ? rd.prio[PRIORITY_BITS-1:0] : r_best;
    assign n_dest  = take ? cand : r_dest;

    // moves that shift current into last
    always_comb begin
        mv_en  = 1'b0;
        mv_tgt = r_dest;
        if (scan_done) begin
            mv_en  = n_found;
            mv_tgt = n_dest;
        end else if (r_state == S_EXEC) begin
            case (r_req.op)
                OP_REEVAL: begin
                    if (cur_ok && !r_en[r_cur]) begin
                        if (r_fb_ok[r_cur] && fits(r_fb[r_cur], r_state_count)) begin
                            mv_en  = 1'b1;
                            mv_tgt = r_fb[r_cur];
                        end else if (default_ok) begin
                            mv_en  = 1'b1;
                            mv_tgt = r_default_state;
                        end
                    end
                end
                OP_FORCE: begin
                    if (!r_req.enter_default && fits(r_req.state_idx, r_state_count)) begin
                        mv_en  = 1'b1;
                        mv_tgt = r_req.state_idx;
                    end
                end
                default: begin
                    mv_en = 1'b0;
                end
            endcase
        end
    end

    assign resp_load = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);

    ppfe_slot_ram #(
        .SLOTS_PER_STATE (SLOTS_PER_STATE),
        .PRIORITY_BITS   (PRIORITY_BITS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_ready   (ram_ready),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (scan_issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count   <= 5'd16;
            r_event_count   <= 5'd16;
            r_default_state <= 4'd0;
            r_default_set   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STATE_COUNT:   r_state_count   <= i_cfg_data;
                CFG_EVENT_COUNT:   r_event_count   <= i_cfg_data;
                CFG_DEFAULT_STATE: r_default_state <= i_cfg_data[3:0];
                CFG_DEFAULT_SET:   r_default_set   <= i_cfg_data[0];
                default:           r_default_set   <= r_default_set;
            endcase
        end
    end

    // fallback targets, read only under r_fb_ok; a refused write keeps the old one
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_req.op == OP_WR_FB && r_req.fallback_valid
                && fits(r_req.state_idx, r_state_count)
                && fits(r_req.fallback_idx, r_state_count)) begin
            r_fb[r_req.state_idx] <= r_req.fallback_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_best <= n_best;
            r_dest <= n_dest;
        end
        if (in_acc) begin
            r_req <= i_in_req;
        end
        if (resp_load) begin
            r_out.current_state  <= r_cur;
            r_out.current_valid  <= r_cur_known;
            r_out.previous_state <= r_prev;
            r_out.changed        <= r_chg;
            r_out.accepted       <= r_acc;
        end
    end

    // sequencer and engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_cur        <= 4'd0;
            r_cur_known  <= 1'b0;
            r_prev       <= 4'd0;
            r_prev_known <= 1'b0;
            r_en         <= '1;
            r_fb_ok      <= '0;
            r_slot       <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_acc        <= 1'b0;
            r_chg        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (resp_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (mv_en) begin
                r_prev       <= r_cur;
                r_prev_known <= r_cur_known;
                r_cur        <= mv_tgt;
                r_cur_known  <= 1'b1;
                r_chg        <= 1'b1;
            end

            case (r_state)
                S_INIT: begin
                    if (ram_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                    r_acc   <= 1'b0;
                    if (!mv_en) begin
                        r_chg <= 1'b0;
                    end
                    case (r_req.op)
                        OP_WR_SLOT: begin
                            r_acc <= slot_wr_ok;
                        end
                        OP_WR_EN: begin
                            if (fits(r_req.state_idx, r_state_count)) begin
                                r_en[r_req.state_idx] <= r_req.enable;
                                r_acc                 <= 1'b1;
                            end
                        end
                        OP_WR_FB: begin
                            if (fits(r_req.state_idx, r_state_count)) begin
                                if (!r_req.fallback_valid) begin
                                    r_fb_ok[r_req.state_idx] <= 1'b0;
                                    r_acc                    <= 1'b1;
                                end else if (fits(r_req.fallback_idx, r_state_count)) begin
                                    r_fb_ok[r_req.state_idx] <= 1'b1;
                                    r_acc                    <= 1'b1;
                                end
                            end
                        end
                        OP_EVENT: begin
                            if (fits(r_req.event_id, r_event_count) && cur_ok) begin
                                r_acc   <= 1'b1;
                                r_slot  <= '0;
                                r_pend  <= 1'b0;
                                r_found <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                        OP_REEVAL: begin
                            r_acc <= cur_ok;
                        end
                        OP_FORCE: begin
                            if (r_req.enter_default) begin
                                // both last and current take the default
                                if (default_ok) begin
                                    r_prev       <= r_default_state;
                                    r_prev_known <= 1'b1;
                                    r_cur        <= r_default_state;
                                    r_cur_known  <= 1'b1;
                                    r_chg        <= 1'b1;
                                    r_acc        <= 1'b1;
                                end
                            end else begin
                                r_acc <= fits(r_req.state_idx, r_state_count);
                            end
                        end
                        default: begin
                            r_acc <= 1'b0;
                        end
                    endcase
                end
                S_SCAN: begin
                    r_slot  <= r_slot + (SW + 1)'(scan_issue);
                    r_pend  <= scan_issue;
                    r_found <= n_found;
                    if (scan_done) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (resp_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `PPFE_ASSERT_NXT(a_accept_to_exec, in_acc, r_state == S_EXEC, "request not decoded")
    `PPFE_ASSERT_IMP(a_changed_accepted, o_out_valid, !o_out_rsp.changed || o_out_rsp.accepted, "change on refused request")
    `PPFE_ASSERT_IMP(a_changed_known, o_out_valid && o_out_rsp.changed, o_out_rsp.current_valid, "change without current state")
    `PPFE_ASSERT_IMP(a_scan_bound, r_state == S_SCAN, r_slot <= SLOTS_C, "slot walk overran")
    `PPFE_ASSERT_IMP(a_scan_dest, r_state == S_SCAN && r_found, r_en[r_dest], "chosen target disabled")

endmodule
